// ===== src/runway_priority_queue_scheduler_assert.svh =====
// Assertion helpers for the runway scheduler.
`ifndef RUNWAY_PRIORITY_QUEUE_SCHEDULER_ASSERT_SVH
`define RUNWAY_PRIORITY_QUEUE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rps_pkg.sv =====
package rps_pkg;

    localparam int LIMIT_W = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    localparam logic [1:0] OP_LAND    = 2'd0;
    localparam logic [1:0] OP_TAKEOFF = 2'd1;
    // any other opcode is a service tick

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_REFUSED  = 3'd1;
    localparam logic [2:0] ST_IDLE     = 3'd2;
    localparam logic [2:0] ST_LANDED   = 3'd3;
    localparam logic [2:0] ST_TOOK_OFF = 3'd4;

    typedef struct packed {
        logic [19:0] start;
        logic [15:0] id;
    } t_entry;

    typedef struct packed {
        logic [5:0]  pad;
        logic [19:0] time_now;
        logic [19:0] plane_start;
        logic [15:0] new_plane_id;
        logic [1:0]  opcode;
    } t_item;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic land_req;
        logic land_ref;
        logic to_req;
        logic to_ref;
        logic land_srv;
        logic to_srv;
        logic idle;
    } t_stat_evt;

    typedef struct packed {
        logic [31:0] idle_ticks;
        logic [47:0] takeoff_wait_total;
        logic [47:0] land_wait_total;
        logic [31:0] takeoffs;
        logic [31:0] landings;
        logic [31:0] takeoff_refused;
        logic [31:0] takeoff_requests;
        logic [31:0] land_refused;
        logic [31:0] land_requests;
    } t_stat_vals;

    typedef struct packed {
        logic        pad;
        t_stat_vals  stats;
        logic [19:0] served_plane_start;
        logic [15:0] served_plane_id;
        logic [2:0]  status;
    } t_result;

endpackage

// ===== src/runway_priority_queue_scheduler.sv =====
// Channel    Direction  Signals                                   Content
// s_axis     in         s_axis_tvalid/tready/tdata[63:0]          request or service tick
// m_axis     out        m_axis_tvalid/tready/tdata[359:0]         status, served plane, counters
// cfg        in         i_cfg_valid/o_cfg_ready/i_cfg_data[4:0]   admission limit per queue
//
// Each item is handled in S_IDLE then S_EXEC: the accept beat issues the queue RAM
// reads at both heads, and S_EXEC uses the read data and writes back.
// The output register holds one result; S_EXEC waits while it is full and not taken.
// Reset is synchronous, active low; queue RAM contents are not cleared.
// cfg is always ready.
`include "runway_priority_queue_scheduler_assert.svh"

module runway_priority_queue_scheduler #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // opcode[1:0], new_plane_id[17:2], plane_start[37:18], time_now[57:38], zero pad
    input  logic [63:0]                 s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // status[2:0], served_plane_id[18:3], served_plane_start[38:19],
    // land_requests[70:39], land_refused[102:71], takeoff_requests[134:103],
    // takeoff_refused[166:135], landings[198:167], takeoffs[230:199],
    // land_wait_total[278:231], takeoff_wait_total[326:279], idle_ticks[358:327], pad
    output logic [359:0]                m_axis_tdata,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rps_pkg::LIMIT_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic [rps_pkg::LIMIT_W-1:0] r_limit;
    rps_pkg::t_item   w_in;
    rps_pkg::t_item   r_item;
    rps_pkg::t_result r_out, n_out;
    logic             r_out_valid;
    logic             w_accept, w_go;
    rps_pkg::t_q_cmd  w_land_cmd, w_to_cmd;
    rps_pkg::t_q_stat w_land_stat, w_to_stat;
    rps_pkg::t_entry  w_land_rd, w_to_rd, w_new;
    rps_pkg::t_stat_evt  w_evt;
    rps_pkg::t_stat_vals w_stats;
    logic [19:0]      w_wait_start;

    assign w_in          = rps_pkg::t_item'(s_axis_tdata);
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_go          = (r_state == S_EXEC) && (!r_out_valid || m_axis_tready);
    assign o_cfg_ready   = 1'b1;

    assign w_new.id    = r_item.new_plane_id;
    assign w_new.start = r_item.plane_start;

    always_comb begin
        w_land_cmd = '0;
        w_to_cmd   = '0;
        w_evt      = '0;
        n_out      = '0;
        n_out.status = rps_pkg::ST_IDLE;
        if (w_go) begin
            case (r_item.opcode)
                rps_pkg::OP_LAND: begin
                    w_evt.land_req = 1'b1;
                    if (w_land_stat.full) begin
                        w_evt.land_ref = 1'b1;
                        n_out.status   = rps_pkg::ST_REFUSED;
                    end else begin
                        w_land_cmd.push = 1'b1;
                        n_out.status    = rps_pkg::ST_ACCEPTED;
                    end
                end
                rps_pkg::OP_TAKEOFF: begin
                    w_evt.to_req = 1'b1;
                    if (w_to_stat.full) begin
                        w_evt.to_ref = 1'b1;
                        n_out.status = rps_pkg::ST_REFUSED;
                    end else begin
                        w_to_cmd.push = 1'b1;
                        n_out.status  = rps_pkg::ST_ACCEPTED;
                    end
                end
                default: begin
                    // service tick: landing first, then takeoff
                    if (!w_land_stat.empty) begin
                        w_land_cmd.pop           = 1'b1;
                        w_evt.land_srv           = 1'b1;
                        n_out.status             = rps_pkg::ST_LANDED;
                        n_out.served_plane_id    = w_land_rd.id;
                        n_out.served_plane_start = w_land_rd.start;
                    end else if (!w_to_stat.empty) begin
                        w_to_cmd.pop             = 1'b1;
                        w_evt.to_srv             = 1'b1;
                        n_out.status             = rps_pkg::ST_TOOK_OFF;
                        n_out.served_plane_id    = w_to_rd.id;
                        n_out.served_plane_start = w_to_rd.start;
                    end else begin
                        w_evt.idle   = 1'b1;
                        n_out.status = rps_pkg::ST_IDLE;
                    end
                end
            endcase
        end
        n_out.stats = w_stats;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_EXEC;
            S_EXEC:  if (w_go)     n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= rps_pkg::LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= w_in;
        end
        if (w_go) begin
            r_out <= n_out;
        end
    end

    // RAM reads are issued on the accept beat; writes land in the exec cycle,
    // so a later accept always sees them.
    rps_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_land_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_limit   (r_limit),
        .i_rd      (w_accept),
        .i_cmd     (w_land_cmd),
        .i_wr_data (w_new),
        .o_rd_data (w_land_rd),
        .o_stat    (w_land_stat)
    );

    rps_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_takeoff_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_limit   (r_limit),
        .i_rd      (w_accept),
        .i_cmd     (w_to_cmd),
        .i_wr_data (w_new),
        .o_rd_data (w_to_rd),
        .o_stat    (w_to_stat)
    );

    assign w_wait_start = w_land_stat.empty ? w_to_rd.start : w_land_rd.start;

    rps_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (w_evt),
        .i_now   (r_item.time_now),
        .i_start (w_wait_start),
        .o_next  (w_stats)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    `RPS_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, w_accept,
        (r_state == S_EXEC) && !s_axis_tready, "accept did not enter exec")
    `RPS_ASSERT_NEXT(a_exec_delivers, i_clk, i_rst_n, w_go,
        m_axis_tvalid && s_axis_tready, "exec cycle did not load a result")
    `RPS_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, w_land_cmd.push || w_to_cmd.push,
        !(w_land_cmd.push && w_land_stat.full) && !(w_to_cmd.push && w_to_stat.full),
        "push into a full queue")

endmodule

// ===== src/rps_ram.sv =====
module rps_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/rps_queue.sv =====
module rps_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [rps_pkg::LIMIT_W-1:0] i_limit,
    input  logic                        i_rd,
    input  rps_pkg::t_q_cmd             i_cmd,
    input  rps_pkg::t_entry             i_wr_data,
    output rps_pkg::t_entry             o_rd_data,
    output rps_pkg::t_q_stat            o_stat
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = (CW > rps_pkg::LIMIT_W) ? CW : rps_pkg::LIMIT_W;

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [LW-1:0] w_lim_raw, w_lim;
    logic [AW:0]   w_sum;
    logic [AW-1:0] w_tail;
    logic [$bits(rps_pkg::t_entry)-1:0] w_rd_raw;

    // admission limit is capped at the physical depth
    assign w_lim_raw = LW'(i_limit);
    assign w_lim     = (w_lim_raw > LW'(QUEUE_DEPTH)) ? LW'(QUEUE_DEPTH) : w_lim_raw;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (LW'(r_count) >= w_lim);

    assign w_sum  = (AW+1)'(r_head) + (AW+1)'(r_count);
    assign w_tail = (w_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                    AW'(w_sum - (AW+1)'(QUEUE_DEPTH)) : AW'(w_sum);

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
            n_head  = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    rps_ram #(
        .WIDTH ($bits(rps_pkg::t_entry)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.push),
        .i_wr_addr (w_tail),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_rd),
        .i_rd_addr (r_head),
        .o_rd_data (w_rd_raw)
    );

    assign o_rd_data = rps_pkg::t_entry'(w_rd_raw);

endmodule

// ===== src/rps_stats.sv =====
module rps_stats (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rps_pkg::t_stat_evt  i_evt,
    input  logic [19:0]         i_now,
    input  logic [19:0]         i_start,
    output rps_pkg::t_stat_vals o_next
);

    rps_pkg::t_stat_vals r_vals, n_vals;
    logic [19:0] w_wait;

    function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic en);
        logic [31:0] res;
        res = v;
        if (en && (v != '1)) begin
            res = v + 32'd1;
        end
        return res;
    endfunction

    function automatic logic [47:0] sat_add(input logic [47:0] v, input logic [19:0] d,
                                            input logic en);
        logic [48:0] sum;
        logic [47:0] res;
        sum = {1'b0, v} + 49'(d);
        res = v;
        if (en) begin
            res = sum[48] ? '1 : sum[47:0];
        end
        return res;
    endfunction

    // late start counts as zero wait
    assign w_wait = (i_now > i_start) ? (i_now - i_start) : '0;

    always_comb begin
        n_vals                    = r_vals;
        n_vals.land_requests      = sat_inc(r_vals.land_requests, i_evt.land_req);
        n_vals.land_refused       = sat_inc(r_vals.land_refused, i_evt.land_ref);
        n_vals.takeoff_requests   = sat_inc(r_vals.takeoff_requests, i_evt.to_req);
        n_vals.takeoff_refused    = sat_inc(r_vals.takeoff_refused, i_evt.to_ref);
        n_vals.landings           = sat_inc(r_vals.landings, i_evt.land_srv);
        n_vals.takeoffs           = sat_inc(r_vals.takeoffs, i_evt.to_srv);
        n_vals.idle_ticks         = sat_inc(r_vals.idle_ticks, i_evt.idle);
        n_vals.land_wait_total    = sat_add(r_vals.land_wait_total, w_wait, i_evt.land_srv);
        n_vals.takeoff_wait_total = sat_add(r_vals.takeoff_wait_total, w_wait, i_evt.to_srv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vals <= '0;
        end else begin
            r_vals <= n_vals;
        end
    end

    assign o_next = n_vals;

endmodule
